### design/tcw_pkg.sv
`default_nettype none

package tcw_pkg;

  // screen geometry defaults
  localparam int DEF_COLUMNS = 80;
  localparam int DEF_ROWS    = 25;

  // fixed field widths
  localparam int CELL_INDEX_W = 11;
  localparam int CFG_ADDR_W   = 2;
  localparam int CFG_DATA_W   = 32;

  // character and attribute constants
  localparam logic [7:0] NEWLINE_CODE = 8'd10;
  localparam logic [7:0] SPACE_CODE   = 8'd32;
  localparam logic [7:0] RESET_COLOR  = 8'h1F;

  // operation codes
  localparam logic [1:0] OP_PUT   = 2'd0;
  localparam logic [1:0] OP_READ  = 2'd1;
  localparam logic [1:0] OP_CLEAR = 2'd2;

  // register map
  localparam logic [CFG_ADDR_W-1:0] REG_TEXT_COLOR = CFG_ADDR_W'(0);

  typedef struct packed {
    logic [1:0]              op;
    logic [7:0]              char_code;
    logic [CELL_INDEX_W-1:0] cell_index;
  } tcw_in_t;

  typedef struct packed {
    logic [15:0] cell_value;
    logic [4:0]  cursor_row;
    logic [6:0]  cursor_column;
  } tcw_out_t;

  typedef enum logic [2:0] {
    ST_FILL,
    ST_IDLE,
    ST_PUT,
    ST_READ,
    ST_DONE
  } tcw_state_t;

  // top level to core
  typedef struct packed {
    logic start;
    logic res_take;
  } tcw_ctl_t;

  // core to top level
  typedef struct packed {
    logic idle;
    logic res_valid;
  } tcw_stat_t;

endpackage

`default_nettype wire

### design/text_console_writer.sv
`default_nettype none

// channel   direction  handshake             payload
// in_       input      in_valid / in_stall   tcw_in_t  (op, char_code, cell_index)
// out_      output     out_valid / out_stall tcw_out_t (cell_value, cursor_row, cursor_column)
// cfg (apb) input      psel, penable, pwrite register text_color at byte address 0
//
// one item at a time: a printable character is written in ST_PUT, a read fetched in ST_READ
// (skipped off screen); newline and op 3 go straight to ST_DONE; a scroll first blanks one
// row of cells through the memory write port; clear screen blanks all ROWS*COLUMNS cells,
// one cell written per cycle. after reset a clearing pass blanks the whole memory; in_stall is high.
// the output register holds a result under out_stall while the next item is taken;
// the core then waits with its own result until the output register frees up.

module text_console_writer
  import tcw_pkg::*;
#(
  parameter int COLUMNS = DEF_COLUMNS,
  parameter int ROWS    = DEF_ROWS
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  in_valid,
  output logic                       in_stall,
  input  wire tcw_in_t               in_item,
  output logic                       out_valid,
  input  wire logic                  out_stall,
  output tcw_out_t                   out_item,
  input  wire logic                  psel,
  input  wire logic                  penable,
  input  wire logic                  pwrite,
  input  wire logic [CFG_ADDR_W-1:0] paddr,
  input  wire logic [CFG_DATA_W-1:0] pwdata,
  output logic [CFG_DATA_W-1:0]      prdata,
  output logic                       pready
);

  logic       [7:0] text_color_r;
  logic             cfg_wr;
  tcw_ctl_t         ctl;
  tcw_stat_t        stat;
  tcw_out_t         core_res;
  logic             out_valid_r, out_valid_nxt;
  tcw_out_t         out_item_r;
  logic             out_load;

  // configuration register
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready && (paddr == REG_TEXT_COLOR);
  assign prdata = (paddr == REG_TEXT_COLOR) ? CFG_DATA_W'(text_color_r) : '0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      text_color_r <= RESET_COLOR;
    end else if (cfg_wr) begin
      text_color_r <= pwdata[7:0];
    end
  end

  // input transfer goes straight to the core
  assign in_stall     = !stat.idle;
  assign ctl.start    = in_valid && stat.idle;
  assign ctl.res_take = out_load;

  tcw_core #(
    .COLUMNS (COLUMNS),
    .ROWS    (ROWS)
  ) u_core (
    .clk        (clk),
    .rst_n      (rst_n),
    .ctl        (ctl),
    .item       (in_item),
    .text_color (text_color_r),
    .stat       (stat),
    .res        (core_res)
  );

  // output register
  assign out_load = stat.res_valid && (!out_valid_r || !out_stall);

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (out_load) begin
      out_valid_nxt = 1'b1;
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_item_r <= core_res;
    end
  end

  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

`ifndef ASSERT_OFF
  // an accepted item always leaves the core busy
  a_start_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall) |=> !stat.idle)
    else $error("core idle after input transfer");

  // a blocked result stays in the core until the output register frees up
  a_res_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (stat.res_valid && out_valid_r && out_stall) |=> stat.res_valid)
    else $error("result dropped while output blocked");

  // a register write lands in the colour register
  a_cfg_write: assert property (@(posedge clk) disable iff (!rst_n)
    cfg_wr |=> (text_color_r == $past(pwdata[7:0])))
    else $error("text colour write lost");
`endif

endmodule

`default_nettype wire

### design/tcw_core.sv
`default_nettype none

module tcw_core
  import tcw_pkg::*;
#(
  parameter int COLUMNS = DEF_COLUMNS,
  parameter int ROWS    = DEF_ROWS
) (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire tcw_ctl_t   ctl,
  input  wire tcw_in_t    item,
  input  wire logic [7:0] text_color,
  output tcw_stat_t       stat,
  output tcw_out_t        res
);

  localparam int CELLS  = COLUMNS * ROWS;
  localparam int ADDR_W = $clog2(CELLS);
  localparam int SUM_W  = ADDR_W + 1;
  localparam int ROW_W  = $clog2(ROWS);
  localparam int COL_W  = $clog2(COLUMNS + 1);
  localparam int IDX_W  = ((ADDR_W > CELL_INDEX_W) ? ADDR_W : CELL_INDEX_W) + 1;

  localparam logic [ADDR_W-1:0] LAST_CELL = ADDR_W'(CELLS - 1);
  localparam logic [ADDR_W-1:0] COLS_A    = ADDR_W'(COLUMNS);
  localparam logic [SUM_W-1:0]  CELLS_S   = SUM_W'(CELLS);
  localparam logic [IDX_W-1:0]  CELLS_I   = IDX_W'(CELLS);
  localparam logic [COL_W-1:0]  COLS_C    = COL_W'(COLUMNS);
  localparam logic [ROW_W-1:0]  LAST_ROW  = ROW_W'(ROWS - 1);

  // cell memory, rows kept in a ring starting at base_r
  logic [15:0]       mem [CELLS];
  logic [15:0]       rd_data_r;
  logic              mem_we;
  logic [ADDR_W-1:0] mem_waddr;
  logic [15:0]       mem_wdata;
  logic [ADDR_W-1:0] mem_raddr;

  tcw_state_t        state_r, state_nxt;
  logic [ROW_W-1:0]  row_r, row_nxt;
  logic [COL_W-1:0]  col_r, col_nxt;
  logic [ADDR_W-1:0] row_base_r, row_base_nxt;
  logic [ADDR_W-1:0] base_r, base_nxt;
  logic [ADDR_W-1:0] fill_addr_r, fill_addr_nxt;
  logic [ADDR_W-1:0] fill_end_r, fill_end_nxt;
  logic [7:0]        fill_color_r, fill_color_nxt;
  logic              fill_reply_r, fill_reply_nxt;
  logic              put_pend_r, put_pend_nxt;
  logic [7:0]        ch_r, ch_nxt;
  logic [15:0]       value_r, value_nxt;

  logic [SUM_W-1:0]  base_sum;
  logic [ADDR_W-1:0] base_adv;
  logic [SUM_W-1:0]  put_sum;
  logic [ADDR_W-1:0] put_addr;
  logic [IDX_W-1:0]  idx_ext;
  logic [IDX_W-1:0]  rd_sum;
  logic [IDX_W-1:0]  rd_wrapped;
  logic              in_range;
  logic              is_nl;
  logic              wrap;

  // ring start after a scroll
  assign base_sum = {1'b0, base_r} + {1'b0, COLS_A};
  assign base_adv = (base_sum >= CELLS_S) ? ADDR_W'(base_sum - CELLS_S) : ADDR_W'(base_sum);

  // physical address of the cursor cell
  assign put_sum  = {1'b0, row_base_r} + {1'b0, base_r} + SUM_W'(col_r);
  assign put_addr = (put_sum >= CELLS_S) ? ADDR_W'(put_sum - CELLS_S) : ADDR_W'(put_sum);

  // physical address of a read request
  assign idx_ext    = IDX_W'(item.cell_index);
  assign in_range   = idx_ext < CELLS_I;
  assign rd_sum     = idx_ext + IDX_W'(base_r);
  assign rd_wrapped = (rd_sum >= CELLS_I) ? (rd_sum - CELLS_I) : rd_sum;
  assign mem_raddr  = ADDR_W'(rd_wrapped);

  assign is_nl = item.char_code == NEWLINE_CODE;
  assign wrap  = (col_r >= COLS_C) || is_nl;

  // memory port
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    rd_data_r <= mem[mem_raddr];
  end

  // state register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_FILL;
      row_r        <= '0;
      col_r        <= '0;
      row_base_r   <= '0;
      base_r       <= '0;
      fill_addr_r  <= '0;
      fill_end_r   <= LAST_CELL;
      fill_color_r <= RESET_COLOR;
      fill_reply_r <= 1'b0;
      put_pend_r   <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      row_r        <= row_nxt;
      col_r        <= col_nxt;
      row_base_r   <= row_base_nxt;
      base_r       <= base_nxt;
      fill_addr_r  <= fill_addr_nxt;
      fill_end_r   <= fill_end_nxt;
      fill_color_r <= fill_color_nxt;
      fill_reply_r <= fill_reply_nxt;
      put_pend_r   <= put_pend_nxt;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    ch_r    <= ch_nxt;
    value_r <= value_nxt;
  end

  // sequencer
  always_comb begin
    state_nxt      = state_r;
    row_nxt        = row_r;
    col_nxt        = col_r;
    row_base_nxt   = row_base_r;
    base_nxt       = base_r;
    fill_addr_nxt  = fill_addr_r;
    fill_end_nxt   = fill_end_r;
    fill_color_nxt = fill_color_r;
    fill_reply_nxt = fill_reply_r;
    put_pend_nxt   = put_pend_r;
    ch_nxt         = ch_r;
    value_nxt      = value_r;
    mem_we         = 1'b0;
    mem_waddr      = fill_addr_r;
    mem_wdata      = {fill_color_r, SPACE_CODE};

    unique case (state_r)
      // blank a run of cells, one a cycle
      ST_FILL: begin
        mem_we = 1'b1;
        if (fill_addr_r == fill_end_r) begin
          if (!fill_reply_r) begin
            state_nxt = ST_IDLE;
          end else if (put_pend_r) begin
            state_nxt = ST_PUT;
          end else begin
            state_nxt = ST_DONE;
          end
        end else begin
          fill_addr_nxt = fill_addr_r + 1'b1;
        end
      end

      ST_IDLE: begin
        if (ctl.start) begin
          value_nxt = '0;
          unique case (item.op)
            OP_PUT: begin
              ch_nxt       = item.char_code;
              put_pend_nxt = !is_nl;
              state_nxt    = is_nl ? ST_DONE : ST_PUT;
              if (wrap) begin
                col_nxt = '0;
                if (row_r >= LAST_ROW) begin
                  // scroll: move the ring start, blank the old top row
                  base_nxt       = base_adv;
                  fill_addr_nxt  = base_r;
                  fill_end_nxt   = base_r + COLS_A - 1'b1;
                  fill_color_nxt = text_color;
                  fill_reply_nxt = 1'b1;
                  state_nxt      = ST_FILL;
                end else begin
                  row_nxt      = row_r + 1'b1;
                  row_base_nxt = row_base_r + COLS_A;
                end
              end
            end
            OP_READ: begin
              state_nxt = in_range ? ST_READ : ST_DONE;
            end
            OP_CLEAR: begin
              row_nxt        = '0;
              col_nxt        = '0;
              row_base_nxt   = '0;
              base_nxt       = '0;
              fill_addr_nxt  = '0;
              fill_end_nxt   = LAST_CELL;
              fill_color_nxt = text_color;
              fill_reply_nxt = 1'b1;
              put_pend_nxt   = 1'b0;
              state_nxt      = ST_FILL;
            end
            default: begin
              state_nxt = ST_DONE;
            end
          endcase
        end
      end

      // write the character at the cursor
      ST_PUT: begin
        mem_we    = 1'b1;
        mem_waddr = put_addr;
        mem_wdata = {text_color, ch_r};
        col_nxt   = col_r + 1'b1;
        state_nxt = ST_DONE;
      end

      ST_READ: begin
        value_nxt = rd_data_r;
        state_nxt = ST_DONE;
      end

      ST_DONE: begin
        if (ctl.res_take) begin
          state_nxt = ST_IDLE;
        end
      end

      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // status and result
  assign stat.idle          = state_r == ST_IDLE;
  assign stat.res_valid     = state_r == ST_DONE;
  assign res.cell_value     = value_r;
  assign res.cursor_row     = 5'(row_r);
  assign res.cursor_column  = 7'(col_r);

endmodule

`default_nettype wire

### tb/sv/tb_top.sv
`timescale 1ns / 1ps

import tcw_pkg::*;

// screen model and queue of pending cursor/cell results
class console_scoreboard;
  localparam int COLUMNS    = DEF_COLUMNS;
  localparam int ROWS       = DEF_ROWS;
  localparam int CELL_COUNT = COLUMNS * ROWS;

  logic [15:0] screen [CELL_COUNT];
  logic [4:0]  row;
  logic [6:0]  col;
  logic [7:0]  color;
  tcw_out_t    expected_q [$];
  int          mismatches;

  function new();
    row        = '0;
    col        = '0;
    color      = RESET_COLOR;
    mismatches = 0;
    blank_from(0);
  endfunction

  // spaces in the current color from one cell to the end of the screen
  function void blank_from(int first);
    for (int i = first; i < CELL_COUNT; i++) screen[i] = {color, SPACE_CODE};
  endfunction

  function void set_color(logic [7:0] c);
    color = c;
  endfunction

  function int pending();
    return expected_q.size();
  endfunction

  // update the screen for one accepted input transfer and queue its result
  function void note_input(tcw_in_t it);
    tcw_out_t res;
    res = '0;
    case (it.op)
      OP_PUT: begin
        // wrap or newline: column home, then next row or scroll
        if (col >= COLUMNS || it.char_code == NEWLINE_CODE) begin
          col = '0;
          if (row >= ROWS - 1) begin
            for (int i = 0; i < CELL_COUNT - COLUMNS; i++) screen[i] = screen[i + COLUMNS];
            blank_from(CELL_COUNT - COLUMNS);
          end else begin
            row = row + 1'b1;
          end
        end
        if (it.char_code != NEWLINE_CODE) begin
          screen[int'(row) * COLUMNS + int'(col)] = {color, it.char_code};
          col = col + 1'b1;
        end
      end
      OP_READ: begin
        if (it.cell_index < CELL_COUNT) res.cell_value = screen[it.cell_index];
      end
      OP_CLEAR: begin
        blank_from(0);
        row = '0;
        col = '0;
      end
      default: ;
    endcase
    res.cursor_row    = row;
    res.cursor_column = col;
    expected_q.push_back(res);
  endfunction

  function void report(string what, logic [15:0] want, logic [15:0] got);
    mismatches++;
    if (mismatches <= 10)
      $display("%0t: mismatch in %s: expected 0x%0h, got 0x%0h", $time, what, want, got);
  endfunction

  // compare one output transfer against the oldest queued result
  function void check_result(tcw_out_t got);
    tcw_out_t want;
    if (expected_q.size() == 0) begin
      report("unexpected result, cell_value", 16'h0, got.cell_value);
      return;
    end
    want = expected_q.pop_front();
    if (got.cell_value !== want.cell_value)
      report("cell_value", want.cell_value, got.cell_value);
    if (got.cursor_row !== want.cursor_row)
      report("cursor_row", 16'(want.cursor_row), 16'(got.cursor_row));
    if (got.cursor_column !== want.cursor_column)
      report("cursor_column", 16'(want.cursor_column), 16'(got.cursor_column));
  endfunction
endclass

module tb_top;
  localparam int COLUMNS        = DEF_COLUMNS;
  localparam int ROWS           = DEF_ROWS;
  localparam int CELL_COUNT     = COLUMNS * ROWS;
  localparam int INDEX_MAX      = (1 << CELL_INDEX_W) - 1;
  localparam logic [1:0] OP_NOP = 2'd3;
  localparam int ITEMS          = 1650;
  localparam int PHASES         = 7;
  localparam int LONG_HOLD      = 400;
  localparam int WATCHDOG_LIMIT = 20000;
  localparam int TAIL_CYCLES    = 2 * COLUMNS;

  logic                  clk = 1'b0;
  logic                  rst_n;
  logic                  in_valid;
  logic                  in_stall;
  tcw_in_t               in_item;
  logic                  out_valid;
  logic                  out_stall;
  tcw_out_t              out_item;
  logic                  psel;
  logic                  penable;
  logic                  pwrite;
  logic [CFG_ADDR_W-1:0] paddr;
  logic [CFG_DATA_W-1:0] pwdata;
  logic [CFG_DATA_W-1:0] prdata;
  logic                  pready;

  console_scoreboard sb = new();

  int   items_sent  = 0;
  int   burst_left  = 0;
  int   idle_cycles = 0;
  logic hold_req    = 1'b0;

  text_console_writer uut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_item   (in_item),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_item  (out_item),
    .psel      (psel),
    .penable   (penable),
    .pwrite    (pwrite),
    .paddr     (paddr),
    .pwdata    (pwdata),
    .prdata    (prdata),
    .pready    (pready)
  );

  always #5 clk = ~clk;

  // watch both channels at the clock edge
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_valid && !in_stall) sb.note_input(in_item);
      if (out_valid && !out_stall) sb.check_result(out_item);
    end
  end

  // watchdog on cycles without any transfer
  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_valid && !in_stall) || (out_valid && !out_stall) || (psel && penable)) begin
        idle_cycles <= 0;
      end else begin
        idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT) begin
          $display("Test completed with failures");
          $finish;
        end
      end
    end
  end

  // result side: stall segments of random density, plus one long hold-off on request
  initial begin : result_sink
    int stall_pct;
    int len;
    out_stall = 1'b0;
    wait (rst_n === 1'b1);
    @(posedge clk);
    forever begin
      if (hold_req) begin
        out_stall <= 1'b1;
        repeat (LONG_HOLD) @(posedge clk);
        hold_req = 1'b0;
      end else begin
        case ($urandom_range(0, 3))
          0:       stall_pct = 0;
          1:       stall_pct = 25;
          2:       stall_pct = 75;
          default: stall_pct = 100;
        endcase
        len = $urandom_range(1, 60);
        repeat (len) begin
          out_stall <= ($urandom_range(0, 99) < stall_pct);
          @(posedge clk);
        end
      end
    end
  end

  function automatic tcw_in_t make_item(logic [1:0] op, logic [7:0] ch, logic [10:0] idx);
    tcw_in_t it;
    it.op         = op;
    it.char_code  = ch;
    it.cell_index = idx;
    return it;
  endfunction

  // read index: mostly near the cursor row or anywhere on screen, some out of range
  function automatic logic [10:0] pick_index();
    int r;
    r = $urandom_range(0, 99);
    if (r < 45) return 11'(int'(sb.row) * COLUMNS + $urandom_range(0, COLUMNS - 1));
    if (r < 88) return 11'($urandom_range(0, CELL_COUNT - 1));
    return 11'($urandom_range(CELL_COUNT, INDEX_MAX));
  endfunction

  // one input transfer, with random gaps between bursts
  task automatic offer(tcw_in_t it);
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 20);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = $urandom_range(1, 40);
    end
    burst_left--;
    in_item  <= it;
    in_valid <= 1'b1;
    do @(posedge clk); while (in_stall);
    items_sent++;
  endtask

  // stop sending and wait until every queued result has come back
  task automatic wait_drained();
    in_valid <= 1'b0;
    @(posedge clk);
    while (sb.pending() != 0) @(posedge clk);
  endtask

  // register write: setup phase, then access phase until pready
  task automatic write_color(logic [7:0] c);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= REG_TEXT_COLOR;
    pwdata  <= CFG_DATA_W'(c);
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    sb.set_color(c);
  endtask

  // one random stretch of console traffic
  task automatic run_sequence();
    int          kind;
    int          n;
    logic [7:0]  ch;
    kind = $urandom_range(0, 99);
    if (kind < 58) begin
      // short line closed by a newline
      n = $urandom_range(0, 30);
      repeat (n) offer(make_item(OP_PUT, 8'($urandom_range(0, 255)), 11'($urandom_range(0, INDEX_MAX))));
      offer(make_item(OP_PUT, NEWLINE_CODE, 11'($urandom_range(0, INDEX_MAX))));
    end else if (kind < 70) begin
      // long run without newlines: exact full row, or a random length from just short of one row to past two
      n = ($urandom_range(0, 2) == 0) ? COLUMNS : $urandom_range(COLUMNS - 10, 2 * COLUMNS + 10);
      repeat (n) begin
        ch = 8'($urandom_range(0, 254));
        if (ch >= NEWLINE_CODE) ch = ch + 1'b1;
        offer(make_item(OP_PUT, ch, 11'($urandom_range(0, INDEX_MAX))));
      end
      if ($urandom_range(0, 1) == 0)
        offer(make_item(OP_PUT, NEWLINE_CODE, 11'($urandom_range(0, INDEX_MAX))));
    end else if (kind < 87) begin
      n = $urandom_range(1, 8);
      repeat (n) offer(make_item(OP_READ, 8'($urandom_range(0, 255)), pick_index()));
    end else if (kind < 88) begin
      offer(make_item(OP_CLEAR, 8'($urandom_range(0, 255)), 11'($urandom_range(0, INDEX_MAX))));
    end else begin
      // noise over all op codes, the unused one included
      n = $urandom_range(1, 4);
      repeat (n) begin
        if ($urandom_range(0, 1) == 0)
          offer(make_item(OP_NOP, 8'($urandom_range(0, 255)), 11'($urandom_range(0, INDEX_MAX))));
        else
          offer(make_item(2'($urandom_range(0, 3)), 8'($urandom_range(0, 255)), pick_index()));
      end
    end
  endtask

  initial begin : stimulus
    logic [7:0] phase_color;
    rst_n   = 1'b0;
    in_valid = 1'b0;
    in_item = '0;
    psel    = 1'b0;
    penable = 1'b0;
    pwrite  = 1'b0;
    paddr   = '0;
    pwdata  = '0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    // directed: field extremes, every op, out-of-range reads, unused op, clear
    offer(make_item(OP_PUT, 8'h00, 11'h7FF));
    offer(make_item(OP_PUT, 8'hFF, 11'h000));
    offer(make_item(OP_PUT, 8'h41, 11'h555));
    offer(make_item(OP_PUT, NEWLINE_CODE, 11'h2AA));
    offer(make_item(OP_READ, 8'hFF, 11'd0));
    offer(make_item(OP_READ, 8'h00, 11'd1));
    offer(make_item(OP_READ, 8'h00, 11'd3));
    offer(make_item(OP_READ, 8'h00, 11'(COLUMNS)));
    offer(make_item(OP_READ, 8'h00, 11'(CELL_COUNT - 1)));
    offer(make_item(OP_READ, 8'h00, 11'(CELL_COUNT)));
    offer(make_item(OP_READ, 8'hFF, 11'(INDEX_MAX)));
    offer(make_item(OP_NOP, 8'hFF, 11'h7FF));
    offer(make_item(OP_NOP, 8'h00, 11'h000));
    offer(make_item(OP_CLEAR, 8'hFF, 11'h7FF));
    offer(make_item(OP_READ, 8'h00, 11'd0));
    offer(make_item(OP_PUT, NEWLINE_CODE, 11'h000));
    offer(make_item(OP_PUT, 8'h7F, 11'h000));

    // random phases, each with its own text color
    for (int phase = 0; phase < PHASES; phase++) begin
      if (phase > 0) begin
        wait_drained();
        case (phase)
          1:       phase_color = 8'h00;
          2:       phase_color = 8'hFF;
          default: phase_color = 8'($urandom_range(0, 255));
        endcase
        write_color(phase_color);
      end
      if (phase == 1)
        offer(make_item(OP_CLEAR, 8'h00, 11'h000));
      if (phase == 3)
        hold_req = 1'b1;
      while (items_sent < (phase + 1) * ITEMS / PHASES) run_sequence();
    end

    wait_drained();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (sb.mismatches == 0 && sb.pending() == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end
endmodule
